>>> sv/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define MCST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also runs during reset
`define MCST_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mcst_pkg.sv
// shared constants, types and helpers of the soft timer unit
package mcst_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RESULT_LIMIT = 16;
    localparam int NEXP_W       = $clog2(RESULT_LIMIT + 1);
    localparam int CQ_DEPTH     = 2;
    localparam int RES_DEPTH    = 4;

    localparam logic [15:0] CPM_RESET = 16'd16000;

    // input command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_CREATE = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_START  = 3'd3;
    localparam logic [2:0] CMD_STOP   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_VALID = 2'd1;
    localparam logic [1:0] ST_BAD_PARAM = 2'd2;
    localparam logic [1:0] ST_NO_FREE   = 2'd3;

    typedef logic [CH_IDX_W-1:0] t_chan_idx;

    // command class as decided by the front end
    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_CREATE     = 3'd1,
        OP_CREATE_BAD = 3'd2,
        OP_DELETE     = 3'd3,
        OP_START      = 3'd4,
        OP_STOP       = 3'd5,
        OP_BAD_CHAN   = 3'd6
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  chan_field;
        t_chan_idx   chan;
        logic [15:0] period_ms;
        logic        periodic;
        logic [31:0] cycle_now;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] chan;
        logic [1:0] status;
        logic       last;
    } t_result;

    function automatic logic [3:0] chan_to_field(t_chan_idx idx);
        return 4'(32'(idx));
    endfunction

endpackage

>>> sv/mcst_front.sv
// front end: request intake, command classification and command queue
module mcst_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [2:0]        i_cmd,
    input  logic [3:0]        i_channel,
    input  logic [15:0]       i_period_ms,
    input  logic              i_periodic,
    input  logic [31:0]       i_cycle_now,
    output mcst_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop
);
    import mcst_pkg::*;

    localparam int PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CQ_DEPTH + 1);

    t_cmd             w_cls;
    logic             w_keep;
    logic             w_beyond;
    logic             w_wr;
    logic             w_rd;
    t_cmd             r_mem [CQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign w_beyond = (32'(i_channel) >= 32'(NUM_CHANNELS));

    always_comb begin
        w_cls            = '0;
        w_cls.chan_field = i_channel;
        w_cls.chan       = CH_IDX_W'(i_channel);
        w_cls.period_ms  = i_period_ms;
        w_cls.periodic   = i_periodic;
        w_cls.cycle_now  = i_cycle_now;
        w_cls.op         = OP_TICK;
        w_keep           = 1'b1;
        case (i_cmd)
            CMD_TICK: begin
                w_cls.op = OP_TICK;
            end
            CMD_CREATE: begin
                w_cls.op = (i_periodic && (i_period_ms == 16'd0)) ? OP_CREATE_BAD : OP_CREATE;
            end
            CMD_DELETE: begin
                w_cls.op = w_beyond ? OP_BAD_CHAN : OP_DELETE;
            end
            CMD_START: begin
                w_cls.op = w_beyond ? OP_BAD_CHAN : OP_START;
            end
            CMD_STOP: begin
                w_cls.op = w_beyond ? OP_BAD_CHAN : OP_STOP;
            end
            default: begin
                // unknown codes are dropped here and never reach the back end
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_full      = (r_count == CNT_W'(CQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    assign w_wr = i_push && !o_full && w_keep;
    assign w_rd = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(CQ_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_wr && w_rd) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cls;
        end
    end

endmodule

>>> sv/mcst_res_fifo.sv
// result queue between the back end and the result ports
module mcst_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mcst_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_empty,
    input  logic              i_pop,
    output mcst_pkg::t_result o_data
);
    import mcst_pkg::*;

    localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    t_result          r_mem [RES_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(RES_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(RES_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(RES_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_wr && w_rd) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/mcst_back.sv
// back end: channel state and the command sequencer with the tick sweep
module mcst_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  mcst_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output mcst_pkg::t_result o_res
);
    import mcst_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_FIND   = 8'b0000_0100,
        S_START  = 8'b0000_1000,
        S_STATUS = 8'b0001_0000,
        S_SCAN   = 8'b0010_0000,
        S_RELOAD = 8'b0100_0000,
        S_FLUSH  = 8'b1000_0000
    } t_state;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd;
    t_chan_idx               r_idx, n_idx;
    logic [NEXP_W-1:0]       r_nexp, n_nexp;
    logic                    r_hold_v, n_hold_v;
    t_chan_idx               r_hold_ch, n_hold_ch;
    logic [31:0]             r_prod, n_prod;
    logic [15:0]             r_cpm;

    logic [NUM_CHANNELS-1:0] r_valid;
    logic [NUM_CHANNELS-1:0] r_active;
    logic [NUM_CHANNELS-1:0] r_periodic;
    logic [15:0]             r_timeout [NUM_CHANNELS];
    logic [31:0]             r_stamp   [NUM_CHANNELS];
    logic [31:0]             r_remain  [NUM_CHANNELS];

    logic        rd_valid, rd_active, rd_periodic;
    logic [15:0] rd_timeout;
    logic [31:0] rd_stamp, rd_remain;
    logic [31:0] w_prod;
    logic [31:0] w_gap;
    logic        w_last_ch;

    logic        we_valid_set, we_valid_clr;
    logic        we_active_set, we_active_clr;
    logic        we_create;
    logic        we_stamp;
    logic        we_remain;
    logic [31:0] w_remain_val;

    // every channel access goes through the one index register
    assign rd_valid    = r_valid[r_idx];
    assign rd_active   = r_active[r_idx];
    assign rd_periodic = r_periodic[r_idx];
    assign rd_timeout  = r_timeout[r_idx];
    assign rd_stamp    = r_stamp[r_idx];
    assign rd_remain   = r_remain[r_idx];

    assign w_prod    = 32'(rd_timeout) * 32'(r_cpm);
    assign w_gap     = r_cmd.cycle_now - rd_stamp;
    assign w_last_ch = (r_idx == CH_IDX_W'(NUM_CHANNELS - 1));

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_nexp        = r_nexp;
        n_hold_v      = r_hold_v;
        n_hold_ch     = r_hold_ch;
        n_prod        = r_prod;
        o_cmd_pop     = 1'b0;
        o_res_push    = 1'b0;
        o_res         = '0;
        we_valid_set  = 1'b0;
        we_valid_clr  = 1'b0;
        we_active_set = 1'b0;
        we_active_clr = 1'b0;
        we_create     = 1'b0;
        we_stamp      = 1'b0;
        we_remain     = 1'b0;
        w_remain_val  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = S_EXEC;
                    n_nexp    = '0;
                    n_hold_v  = 1'b0;
                    n_idx     = ((i_cmd.op == OP_TICK) || (i_cmd.op == OP_CREATE))
                                ? '0 : i_cmd.chan;
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    OP_TICK: begin
                        n_state = S_SCAN;
                    end
                    OP_CREATE: begin
                        n_state = S_FIND;
                    end
                    OP_CREATE_BAD: begin
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_res      = '{kind: KIND_CREATE, chan: 4'd0,
                                           status: ST_BAD_PARAM, last: 1'b1};
                            n_state    = S_IDLE;
                        end
                    end
                    OP_BAD_CHAN: begin
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_res      = '{kind: KIND_STATUS, chan: r_cmd.chan_field,
                                           status: ST_NOT_VALID, last: 1'b1};
                            n_state    = S_IDLE;
                        end
                    end
                    OP_DELETE: begin
                        if (!i_res_full) begin
                            we_valid_clr  = 1'b1;
                            we_active_clr = 1'b1;
                            o_res_push    = 1'b1;
                            o_res         = '{kind: KIND_STATUS, chan: r_cmd.chan_field,
                                              status: ST_OK, last: 1'b1};
                            n_state       = S_IDLE;
                        end
                    end
                    OP_STOP: begin
                        if (!i_res_full) begin
                            o_res_push    = 1'b1;
                            we_active_clr = rd_valid;
                            o_res         = '{kind: KIND_STATUS, chan: r_cmd.chan_field,
                                              status: rd_valid ? ST_OK : ST_NOT_VALID,
                                              last: 1'b1};
                            n_state       = S_IDLE;
                        end
                    end
                    OP_START: begin
                        if (rd_valid) begin
                            n_prod  = w_prod;
                            n_state = S_START;
                        end else if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_res      = '{kind: KIND_STATUS, chan: r_cmd.chan_field,
                                           status: ST_NOT_VALID, last: 1'b1};
                            n_state    = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FIND: begin
                // lowest free channel, one channel a cycle
                if (!rd_valid) begin
                    if (!i_res_full) begin
                        we_valid_set  = 1'b1;
                        we_active_clr = 1'b1;
                        we_create     = 1'b1;
                        o_res_push    = 1'b1;
                        o_res         = '{kind: KIND_CREATE, chan: chan_to_field(r_idx),
                                          status: ST_OK, last: 1'b1};
                        n_state       = S_IDLE;
                    end
                end else if (w_last_ch) begin
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        o_res      = '{kind: KIND_CREATE, chan: 4'd0,
                                       status: ST_NO_FREE, last: 1'b1};
                        n_state    = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + CH_IDX_W'(1);
                end
            end
            S_START: begin
                if (!i_res_full) begin
                    we_remain    = 1'b1;
                    w_remain_val = r_prod;
                    o_res_push   = 1'b1;
                    if (r_prod == '0) begin
                        // zero count fires at once, stamp untouched
                        we_active_clr = 1'b1;
                        o_res         = '{kind: KIND_EXPIRY, chan: r_cmd.chan_field,
                                          status: ST_OK, last: 1'b0};
                        n_state       = S_STATUS;
                    end else begin
                        we_stamp      = 1'b1;
                        we_active_set = 1'b1;
                        o_res         = '{kind: KIND_STATUS, chan: r_cmd.chan_field,
                                          status: ST_OK, last: 1'b1};
                        n_state       = S_IDLE;
                    end
                end
            end
            S_STATUS: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = '{kind: KIND_STATUS, chan: r_cmd.chan_field,
                                   status: ST_OK, last: 1'b1};
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_nexp == NEXP_W'(RESULT_LIMIT)) begin
                    n_state = S_FLUSH;
                end else if (!(rd_valid && rd_active)) begin
                    if (w_last_ch) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + CH_IDX_W'(1);
                    end
                end else if (w_gap < rd_remain) begin
                    we_stamp     = 1'b1;
                    we_remain    = 1'b1;
                    w_remain_val = rd_remain - w_gap;
                    if (w_last_ch) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + CH_IDX_W'(1);
                    end
                end else if (!(r_hold_v && i_res_full)) begin
                    // expiry: the previous one goes out, this one is held
                    // until we know whether it is the last of the tick
                    if (r_hold_v) begin
                        o_res_push = 1'b1;
                        o_res      = '{kind: KIND_EXPIRY, chan: chan_to_field(r_hold_ch),
                                       status: ST_OK, last: 1'b0};
                    end
                    n_hold_v     = 1'b1;
                    n_hold_ch    = r_idx;
                    n_nexp       = r_nexp + NEXP_W'(1);
                    we_stamp     = 1'b1;
                    we_remain    = 1'b1;
                    w_remain_val = '0;
                    if (rd_periodic) begin
                        n_prod  = w_prod;
                        n_state = S_RELOAD;
                    end else begin
                        we_active_clr = 1'b1;
                        if (w_last_ch) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_idx = r_idx + CH_IDX_W'(1);
                        end
                    end
                end
            end
            S_RELOAD: begin
                we_remain     = 1'b1;
                w_remain_val  = r_prod;
                we_active_clr = (r_prod == '0);
                if (w_last_ch) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx + CH_IDX_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = '{kind: KIND_EXPIRY, chan: chan_to_field(r_hold_ch),
                                   status: ST_OK, last: 1'b1};
                    n_hold_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_nexp   <= '0;
            r_hold_v <= 1'b0;
            r_valid  <= '0;
            r_active <= '0;
            r_cpm    <= CPM_RESET;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_nexp   <= n_nexp;
            r_hold_v <= n_hold_v;
            if (i_cfg_we) begin
                r_cpm <= i_cfg_wdata;
            end
            if (we_valid_set) begin
                r_valid[r_idx] <= 1'b1;
            end else if (we_valid_clr) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (we_active_set) begin
                r_active[r_idx] <= 1'b1;
            end else if (we_active_clr) begin
                r_active[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_ch <= n_hold_ch;
        r_prod    <= n_prod;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (we_create) begin
            r_timeout[r_idx]  <= r_cmd.period_ms;
            r_periodic[r_idx] <= r_cmd.periodic;
        end
        if (we_stamp) begin
            r_stamp[r_idx] <= r_cmd.cycle_now;
        end
        if (we_remain) begin
            r_remain[r_idx] <= w_remain_val;
        end
    end

endmodule

>>> sv/multi_channel_soft_timer_unit.sv
// top level of the multi-channel soft timer unit
//
// usage
//   requests enter through push/full as a queue: a request is taken at a
//   clock edge with push high and full low. each request carries a command
//   (tick, create, delete, start, stop), a channel, a timeout in ms, a
//   periodic flag and the current cycle stamp. unknown commands are dropped.
//   results leave as a queue through empty/pop; the oldest result sits on
//   o_kind/o_channel_out/o_status/o_last while empty is low and is taken at
//   an edge with pop high. o_last marks the final result of one request.
//   cycles_per_ms is written through i_cfg_we/i_cfg_wdata while idle.
// flow
//   a single-result command passes the command queue, the sequencer's idle
//   and exec states and the result queue; start adds a state for the count
//   product. create scans up to NUM_CHANNELS channels, one a cycle. a tick
//   sweeps all NUM_CHANNELS channels one a cycle unless an expiry waits on
//   a full result queue; a periodic reload adds the reload state. a
//   two-entry command queue lets requests arrive while the sequencer works.
// reset and stall
//   synchronous reset frees every channel, empties both queues and sets
//   cycles_per_ms to 16000. while the result queue is full the sequencer
//   holds, then the command queue fills and full goes high.
module multi_channel_soft_timer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_channel,
    input  logic [15:0] i_period_ms,
    input  logic        i_periodic,
    input  logic [31:0] i_cycle_now,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_channel_out,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import mcst_pkg::*;

    // classified command between front and back
    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_pop;
    // result path from the sequencer into the result queue
    t_result w_res_in;
    logic    w_res_push;
    logic    w_res_full;
    t_result w_res_out;

    // front end: takes requests, sorts them into command classes
    mcst_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_channel    (i_channel),
        .i_period_ms  (i_period_ms),
        .i_periodic   (i_periodic),
        .i_cycle_now  (i_cycle_now),
        .o_cmd        (w_cmd),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_pop    (w_cmd_pop)
    );

    // back end: owns channel state, runs create scan, start and tick sweep
    mcst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // result queue decouples the sequencer from a stalled receiver
    mcst_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (w_res_out)
    );

    assign o_kind        = w_res_out.kind;
    assign o_channel_out = w_res_out.chan;
    assign o_status      = w_res_out.status;
    assign o_last        = w_res_out.last;

endmodule

>>> sv/mcst_checker.sv
// port-level checker for the soft timer unit and its bind
`include "assert_macros.svh"

module mcst_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_kind,
    input logic [3:0] o_channel_out,
    input logic [1:0] o_status,
    input logic       o_last
);
    import mcst_pkg::*;

    logic       w_shown;
    logic       w_wait;
    logic [8:0] w_res;
    logic       w_kind_known;
    logic       w_expiry;
    logic       w_create_fail;

    assign w_shown       = !empty;
    assign w_wait        = !empty && !pop;
    assign w_res         = {o_kind, o_channel_out, o_status, o_last};
    assign w_kind_known  = (o_kind == KIND_CREATE) || (o_kind == KIND_STATUS) ||
                           (o_kind == KIND_EXPIRY);
    assign w_expiry      = !empty && (o_kind == KIND_EXPIRY);
    assign w_create_fail = !empty && (o_kind == KIND_CREATE) && (o_status != ST_OK);

    // result queue is empty right after reset
    `MCST_ASSERT_RST(a_empty_after_reset, i_clk, !i_rst_n |=> empty, "results after reset")

    // a waiting result holds until taken
    `MCST_ASSERT(a_res_hold, i_clk, i_rst_n, w_wait |=> (w_shown && $stable(w_res)), "result changed")

    // no result kind beyond timer expiry
    `MCST_ASSERT(a_kind_range, i_clk, i_rst_n, w_shown |-> w_kind_known, "bad result kind")

    // an expiry always carries status ok
    `MCST_ASSERT(a_expiry_ok, i_clk, i_rst_n, w_expiry |-> (o_status == ST_OK), "expiry status")

    // a failed create reports channel zero
    `MCST_ASSERT(a_create_fail_ch, i_clk, i_rst_n, w_create_fail |-> (o_channel_out == 4'd0), "create channel")

endmodule

bind multi_channel_soft_timer_unit mcst_port_checker u_mcst_port_checker (.*);

>>> tb/mcst_checker.sv
// request/result scoreboard for the multi-channel soft timer unit
`timescale 1ns / 1ps

module mcst_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_channel,
    input  logic [15:0] i_period_ms,
    input  logic        i_periodic,
    input  logic [31:0] i_cycle_now,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_channel_out,
    input  logic [1:0]  i_status,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_pending,
    output int          o_error_count,
    output int          o_checked_count,
    output int          o_expiry_count
);
    import mcst_pkg::*;

    // timer pool mirror
    logic [15:0] ms_scale;
    logic        slot_valid     [NUM_CHANNELS];
    logic        slot_armed     [NUM_CHANNELS];
    logic        slot_reload    [NUM_CHANNELS];
    logic [15:0] slot_period_ms [NUM_CHANNELS];
    logic [31:0] slot_stamp     [NUM_CHANNELS];
    logic [31:0] slot_count     [NUM_CHANNELS];

    t_result timer_results_due [$];

    function automatic t_result make_result(logic [1:0] kind, logic [3:0] chan,
                                            logic [1:0] status, logic last);
        t_result r;
        r.kind   = kind;
        r.chan   = chan;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    function automatic logic [31:0] period_cycles(int slot);
        return {16'd0, slot_period_ms[slot]} * {16'd0, ms_scale};
    endfunction

    task automatic predict_timer_results(input logic [2:0] cmd, input logic [3:0] ch,
                                         input logic [15:0] tmo, input logic per,
                                         input logic [31:0] now);
        logic [31:0] gap;
        int          fired [NUM_CHANNELS];
        int          n_fired;
        int          slot;
        n_fired = 0;
        slot    = -1;
        if (cmd == CMD_TICK) begin
            for (int i = 0; i < NUM_CHANNELS && n_fired < RESULT_LIMIT; i++) begin
                if (slot_valid[i] && slot_armed[i]) begin
                    gap           = now - slot_stamp[i];
                    slot_stamp[i] = now;
                    if (gap < slot_count[i]) begin
                        slot_count[i] = slot_count[i] - gap;
                    end else begin
                        slot_count[i] = '0;
                        if (slot_reload[i]) begin
                            slot_count[i] = period_cycles(i);
                            if (slot_count[i] == '0)
                                slot_armed[i] = 1'b0;
                        end else begin
                            slot_armed[i] = 1'b0;
                        end
                        fired[n_fired] = i;
                        n_fired++;
                    end
                end
            end
            for (int k = 0; k < n_fired; k++)
                timer_results_due.push_back(make_result(KIND_EXPIRY, 4'(fired[k]), ST_OK,
                                                        k == n_fired - 1));
        end else if (cmd == CMD_CREATE) begin
            if (per && tmo == '0) begin
                timer_results_due.push_back(make_result(KIND_CREATE, '0, ST_BAD_PARAM, 1'b1));
            end else begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                    if (slot < 0 && !slot_valid[i])
                        slot = i;
                if (slot < 0) begin
                    timer_results_due.push_back(make_result(KIND_CREATE, '0, ST_NO_FREE, 1'b1));
                end else begin
                    slot_valid[slot]     = 1'b1;
                    slot_armed[slot]     = 1'b0;
                    slot_period_ms[slot] = tmo;
                    slot_reload[slot]    = per;
                    timer_results_due.push_back(make_result(KIND_CREATE, 4'(slot), ST_OK, 1'b1));
                end
            end
        end else if (cmd == CMD_DELETE || cmd == CMD_START || cmd == CMD_STOP) begin
            if (int'(ch) >= NUM_CHANNELS) begin
                timer_results_due.push_back(make_result(KIND_STATUS, ch, ST_NOT_VALID, 1'b1));
            end else if (cmd == CMD_DELETE) begin
                slot_valid[ch] = 1'b0;
                slot_armed[ch] = 1'b0;
                timer_results_due.push_back(make_result(KIND_STATUS, ch, ST_OK, 1'b1));
            end else if (!slot_valid[ch]) begin
                timer_results_due.push_back(make_result(KIND_STATUS, ch, ST_NOT_VALID, 1'b1));
            end else begin
                if (cmd == CMD_START) begin
                    slot_count[ch] = period_cycles(ch);
                    // zero count fires at once, stamp untouched
                    if (slot_count[ch] == '0) begin
                        slot_armed[ch] = 1'b0;
                        timer_results_due.push_back(make_result(KIND_EXPIRY, ch, ST_OK, 1'b0));
                    end else begin
                        slot_stamp[ch] = now;
                        slot_armed[ch] = 1'b1;
                    end
                end else begin
                    slot_armed[ch] = 1'b0;
                end
                timer_results_due.push_back(make_result(KIND_STATUS, ch, ST_OK, 1'b1));
            end
        end
        // other command codes are dropped without a result
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            ms_scale = CPM_RESET;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                slot_valid[i]     = 1'b0;
                slot_armed[i]     = 1'b0;
                slot_reload[i]    = 1'b0;
                slot_period_ms[i] = '0;
                slot_stamp[i]     = '0;
                slot_count[i]     = '0;
            end
            timer_results_due.delete();
            o_error_count   = 0;
            o_checked_count = 0;
            o_expiry_count  = 0;
        end else begin
            if (i_cfg_we)
                ms_scale = i_cfg_wdata;
            if (i_push && !i_full)
                predict_timer_results(i_cmd, i_channel, i_period_ms, i_periodic, i_cycle_now);
            if (i_pop && !i_empty) begin
                got = make_result(i_kind, i_channel_out, i_status, i_last);
                o_checked_count++;
                if (got.kind == KIND_EXPIRY)
                    o_expiry_count++;
                if (timer_results_due.size() == 0) begin
                    $display("%0t: unexpected result kind %0d channel %0d status %0d last %0d",
                             $time, got.kind, got.chan, got.status, got.last);
                    o_error_count++;
                end else begin
                    want = timer_results_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected kind %0d channel %0d status %0d last %0d",
                                 $time, want.kind, want.chan, want.status, want.last);
                        $display("%0t:             actual kind %0d channel %0d status %0d last %0d",
                                 $time, got.kind, got.chan, got.status, got.last);
                        o_error_count++;
                    end
                end
            end
        end
        o_pending = timer_results_due.size();
    end

endmodule

>>> tb/tb_top.sv
// stimulus, clock and verdict for the multi-channel soft timer unit
`timescale 1ns / 1ps

module tb_top;
    import mcst_pkg::*;

    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 5;
    // a tick sweeps every channel plus reloads, so this covers a busy sequencer
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_CYCLES     = 400;

    // command codes the block has no meaning for
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;

    // request side
    logic        push;
    logic        full;
    logic [2:0]  req_cmd;
    logic [3:0]  req_channel;
    logic [15:0] req_period_ms;
    logic        req_periodic;
    logic [31:0] req_cycle_now;

    // result side
    logic        empty;
    logic        pop;
    logic [1:0]  res_kind;
    logic [3:0]  res_channel;
    logic [1:0]  res_status;
    logic        res_last;

    logic        cfg_we;
    logic [15:0] cfg_wdata;

    // asks the result side for one long hold-off
    logic        hold_req;

    int          pending;
    int          error_count;
    int          checked_count;
    int          expiry_count;

    // sender bookkeeping
    int                      sent_count;
    int                      burst_left;
    int                      cur_cpm;
    int                      last_alloc;
    logic [31:0]             stamp;
    logic [NUM_CHANNELS-1:0] alloc_mask;

    always #2 i_clk = ~i_clk;

    multi_channel_soft_timer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (req_cmd),
        .i_channel     (req_channel),
        .i_period_ms   (req_period_ms),
        .i_periodic    (req_periodic),
        .i_cycle_now   (req_cycle_now),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (res_kind),
        .o_channel_out (res_channel),
        .o_status      (res_status),
        .o_last        (res_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    mcst_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_cmd           (req_cmd),
        .i_channel       (req_channel),
        .i_period_ms     (req_period_ms),
        .i_periodic      (req_periodic),
        .i_cycle_now     (req_cycle_now),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_kind          (res_kind),
        .i_channel_out   (res_channel),
        .i_status        (res_status),
        .i_last          (res_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_pending       (pending),
        .o_error_count   (error_count),
        .o_checked_count (checked_count),
        .o_expiry_count  (expiry_count)
    );

    // hard stop in case a handshake never completes
    initial begin : watchdog
        #4_000_000;
        $display("timeout: %0d results still outstanding", pending);
        $display("multi_channel_soft_timer_unit regression: fail");
        $finish;
    end

    // result side: pop pattern switches among always, mostly and seldom popping,
    // plus one long hold-off so the block backs up into full
    initial begin : result_drain
        int   hold_left;
        int   mode;
        int   mode_left;
        logic held;
        pop       = 1'b0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 9) < 7);
                    default: pop <= ($urandom_range(0, 9) < 2);
                endcase
            end
        end
    end

    // one request through push/full; called and returns at a falling edge.
    // requests go out in bursts with random gaps, some bursts back to back
    task automatic send_req(input logic [2:0] cmd, input logic [3:0] ch,
                            input logic [15:0] tmo, input logic per,
                            input logic [31:0] now);
        int lowest;
        lowest = -1;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        burst_left--;
        push          <= 1'b1;
        req_cmd       <= cmd;
        req_channel   <= ch;
        req_period_ms <= tmo;
        req_periodic  <= per;
        req_cycle_now <= now;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
        // rough view of which channels are taken, only used to steer stimulus
        last_alloc = -1;
        if (cmd == CMD_CREATE && !(per && tmo == '0)) begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                if (lowest < 0 && !alloc_mask[i])
                    lowest = i;
            if (lowest >= 0) begin
                alloc_mask[lowest] = 1'b1;
                last_alloc         = lowest;
            end
        end else if (cmd == CMD_DELETE) begin
            alloc_mask[ch] = 1'b0;
        end
    endtask

    // mostly a channel that is in use, sometimes any channel
    function automatic logic [3:0] pick_channel();
        logic [3:0] ch;
        ch = 4'($urandom_range(0, 15));
        if (alloc_mask != '0 && $urandom_range(0, 9) < 8)
            while (!alloc_mask[ch]) ch = ch + 4'd1;
        return ch;
    endfunction

    // short timeouts so timers expire within a few requests, now and then any value
    function automatic logic [15:0] pick_timeout();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 5));
    endfunction

    task automatic write_cycles_per_ms(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_cpm    = value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // sender waits until every result is back and the sequencer has gone quiet
    task automatic settle();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_directed();
        stamp = 32'hFFFF_FFF0;
        // periodic create with zero timeout is refused
        send_req(CMD_CREATE, 4'd0, 16'd0, 1'b1, stamp);
        // one-shot with zero timeout: start fires at once, then status ok
        send_req(CMD_CREATE, 4'd0, 16'd0, 1'b0, stamp);
        send_req(CMD_START, 4'd0, 16'd0, 1'b0, stamp);
        // commands on channels never created
        send_req(CMD_START, 4'd9, 16'hFFFF, 1'b1, stamp);
        send_req(CMD_STOP, 4'd15, 16'd0, 1'b0, stamp);
        send_req(CMD_DELETE, 4'd15, 16'd0, 1'b0, stamp);
        for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
            send_req(3'(c), 4'hF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        // nothing armed, tick stays silent
        send_req(CMD_TICK, 4'd0, 16'd0, 1'b0, stamp);
        send_req(CMD_CREATE, 4'd0, 16'hFFFF, 1'b1, stamp);
        send_req(CMD_CREATE, 4'd0, 16'd3, 1'b1, stamp);
        send_req(CMD_CREATE, 4'd0, 16'd2, 1'b0, stamp);
        send_req(CMD_START, 4'd1, 16'd0, 1'b0, stamp);
        send_req(CMD_START, 4'd2, 16'd0, 1'b0, stamp);
        send_req(CMD_START, 4'd3, 16'd0, 1'b0, stamp);
        // one-shot expires, then the periodic one reloads
        send_req(CMD_TICK, 4'd0, 16'd0, 1'b0, stamp + 32'd2);
        send_req(CMD_TICK, 4'd0, 16'd0, 1'b0, stamp + 32'd3);
        // stamp wraps past zero
        send_req(CMD_TICK, 4'd0, 16'd0, 1'b0, stamp + 32'h14);
        send_req(CMD_STOP, 4'd2, 16'd0, 1'b0, stamp + 32'h14);
        // restart of a running channel, then a gap of 2^32 - 1
        send_req(CMD_START, 4'd1, 16'd0, 1'b0, stamp + 32'h14);
        send_req(CMD_TICK, 4'd0, 16'd0, 1'b0, stamp + 32'h13);
        send_req(CMD_STOP, 4'd1, 16'd0, 1'b0, stamp);
        send_req(CMD_DELETE, 4'd1, 16'd0, 1'b0, stamp);
        send_req(CMD_DELETE, 4'd0, 16'd0, 1'b0, stamp);
    endtask

    // mostly create-and-start pairs and ticks, with some lone starts, stop, delete,
    // refused creates and fully random requests mixed in
    task automatic run_random_phase(input int n_items);
        int          done_items;
        int          pick;
        logic [2:0]  cmd;
        logic [15:0] tmo;
        logic        per;
        done_items = 0;
        while (done_items < n_items) begin
            pick  = $urandom_range(0, 99);
            stamp = stamp + $urandom_range(0, cur_cpm);
            if (pick < 30) begin
                tmo = pick_timeout();
                per = 1'($urandom_range(0, 1));
                if (per && tmo == '0)
                    tmo = 16'd1;
                send_req(CMD_CREATE, 4'($urandom_range(0, 15)), tmo, per, stamp);
                stamp = stamp + $urandom_range(0, cur_cpm);
                send_req(CMD_START, (last_alloc >= 0) ? 4'(last_alloc) : pick_channel(),
                         16'($urandom), 1'($urandom_range(0, 1)), stamp);
                done_items += 2;
            end else if (pick < 55) begin
                stamp = stamp + $urandom_range(0, 2 * cur_cpm);
                send_req(CMD_TICK, 4'($urandom_range(0, 15)), 16'($urandom),
                         1'($urandom_range(0, 1)), stamp);
                done_items++;
            end else if (pick < 65) begin
                send_req(CMD_START, pick_channel(), 16'($urandom), 1'($urandom_range(0, 1)), stamp);
                done_items++;
            end else if (pick < 73) begin
                send_req(CMD_STOP, pick_channel(), 16'($urandom), 1'($urandom_range(0, 1)), stamp);
                done_items++;
            end else if (pick < 87) begin
                send_req(CMD_DELETE, pick_channel(), 16'($urandom), 1'($urandom_range(0, 1)), stamp);
                done_items++;
            end else if (pick < 92) begin
                send_req(CMD_CREATE, 4'($urandom_range(0, 15)), 16'd0, 1'b1, stamp);
                done_items++;
            end else begin
                // noise, including jumps of the cycle counter in either direction
                cmd = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 1) == 0)
                    stamp = $urandom;
                send_req(cmd, 4'($urandom_range(0, 15)), 16'($urandom),
                         1'($urandom_range(0, 1)), stamp);
                if (cmd < CMD_RSVD_LO)
                    done_items++;
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] scale;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        req_cmd       = CMD_TICK;
        req_channel   = '0;
        req_period_ms = '0;
        req_periodic  = 1'b0;
        req_cycle_now = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        hold_req      = 1'b0;
        sent_count    = 0;
        burst_left    = 0;
        cur_cpm       = CPM_RESET;
        last_alloc    = -1;
        alloc_mask    = '0;
        stamp         = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed requests run with cycles_per_ms set to 1
        write_cycles_per_ms(16'd1);
        run_directed();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0:       scale = CPM_RESET;
                1:       scale = 16'hFFFF;
                2:       scale = 16'($urandom_range(2, 16));
                3:       scale = 16'($urandom_range(1, 65535));
                default: scale = 16'd1;
            endcase
            write_cycles_per_ms(scale);
            // result side stalls for a long stretch while requests keep coming
            if (phase == 2)
                hold_req <= 1'b1;
            run_random_phase(ITEMS_PER_PHASE);
        end
        settle();

        $display("covered %0d requests under %0d cycles_per_ms settings incl. 1 and 65535",
                 sent_count, NUM_PHASES + 1);
        $display("checked %0d results, %0d of them expiries", checked_count, expiry_count);
        if (error_count == 0 && pending == 0)
            $display("multi_channel_soft_timer_unit regression: pass");
        else
            $display("multi_channel_soft_timer_unit regression: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/mcst_pkg.sv
sv/mcst_front.sv
sv/mcst_res_fifo.sv
sv/mcst_back.sv
sv/multi_channel_soft_timer_unit.sv
sv/mcst_checker.sv
tb/mcst_checker.sv
tb/tb_top.sv
